// ----- sv/rre_pkg.sv -----
// rre_pkg: shared types and constants for the round robin echo ranger
`timescale 1ns / 1ps
`default_nettype none

package rre_pkg;

    localparam int SENSOR_W = 3;
    localparam int STAMP_W  = 16;
    localparam int DIST_W   = 16;
    localparam int CMD_W    = 2;
    localparam int MASK_W   = 8;
    localparam int RIDX_W   = 8;
    localparam int COUNT_W  = 4;

    // item kinds
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_SENSOR_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] SENSOR_COUNT_RESET = 4'd1;

    // floor(d*17/100) == (d * 17 * ceil(2^32/100)) >> 32 for every 16 bit d
    localparam int PROD_W     = 48;
    localparam int DIST_SHIFT = 32;
    localparam logic [PROD_W-1:0] DIST_MULT = 48'd730144441;

    localparam logic [DIST_W-1:0] DIST_BAD_INDEX = 16'hFFFF;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [MASK_W-1:0]  edge_mask;
        logic [STAMP_W-1:0] edge_time;
        logic [RIDX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic                trigger_fire;
        logic [SENSOR_W-1:0] trigger_sensor;
        logic                missed_echo;
        logic [DIST_W-1:0]   distance_mm;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/rre_core.sv -----
// rre_core: sensor scan state, echo stamps, distance store and result logic
`timescale 1ns / 1ps
`default_nettype none

module rre_core #(
    parameter int MAX_SENSORS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire rre_pkg::item_t               item,
    input  wire logic [rre_pkg::COUNT_W-1:0]  sensor_count,
    output rre_pkg::result_t                  result
);

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam logic [rre_pkg::COUNT_W-1:0] MAX_CNT = rre_pkg::COUNT_W'(MAX_SENSORS);
    localparam logic [rre_pkg::COUNT_W-1:0] LAST_SENSOR = rre_pkg::COUNT_W'(7);

    logic [rre_pkg::SENSOR_W-1:0] cur_reg, cur_next;
    logic                         pending_reg, pending_next;
    logic [rre_pkg::STAMP_W-1:0]  start_reg, start_next;
    logic [rre_pkg::STAMP_W-1:0]  end_reg, end_next;
    logic [rre_pkg::DIST_W-1:0]   dist_reg [MAX_SENSORS];

    logic [rre_pkg::COUNT_W-1:0]  eff_count;
    logic [rre_pkg::COUNT_W-1:0]  step_sensor;
    logic                         wrap;
    logic [rre_pkg::STAMP_W-1:0]  delta;
    logic [rre_pkg::PROD_W-1:0]   product;
    logic [rre_pkg::DIST_W-1:0]   dist_val;
    logic                         rd_ok;
    logic                         store_wr;

    always_comb
    begin
        eff_count   = (sensor_count < MAX_CNT) ? sensor_count : MAX_CNT;
        step_sensor = {1'b0, cur_reg} + rre_pkg::COUNT_W'(1);
        wrap        = (step_sensor >= eff_count) || (step_sensor > LAST_SENSOR);
        delta       = end_reg - start_reg;
        product     = rre_pkg::PROD_W'(delta) * rre_pkg::DIST_MULT;
        dist_val    = product[rre_pkg::DIST_SHIFT +: rre_pkg::DIST_W];
        rd_ok       = item.read_index < {4'b0000, eff_count};
    end

    always_comb
    begin
        cur_next     = cur_reg;
        pending_next = pending_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        store_wr     = 1'b0;
        result       = '0;
        unique case (item.cmd)
            rre_pkg::CMD_EDGE:
            begin
                if (item.edge_mask[cur_reg])
                begin
                    if (!pending_reg)
                    begin
                        start_next   = item.edge_time;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        end_next     = item.edge_time;
                        pending_next = 1'b0;
                    end
                end
            end
            rre_pkg::CMD_POLL:
            begin
                if (!pending_reg)
                begin
                    store_wr = 1'b1;
                end
                else
                begin
                    start_next         = '0;
                    end_next           = '0;
                    pending_next       = 1'b0;
                    result.missed_echo = 1'b1;
                end
                cur_next              = wrap ? '0 : step_sensor[rre_pkg::SENSOR_W-1:0];
                result.trigger_fire   = 1'b1;
                result.trigger_sensor = cur_next;
            end
            rre_pkg::CMD_READ:
            begin
                result.distance_mm = rd_ok ? dist_reg[item.read_index[IDX_W-1:0]]
                                           : rre_pkg::DIST_BAD_INDEX;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            pending_reg <= 1'b0;
            start_reg   <= '0;
            end_reg     <= '0;
        end
        else if (advance)
        begin
            cur_reg     <= cur_next;
            pending_reg <= pending_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SENSORS; i++)
            begin
                dist_reg[i] <= '0;
            end
        end
        else if (advance && store_wr)
        begin
            dist_reg[cur_reg[IDX_W-1:0]] <= dist_val;
        end
    end

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < MAX_CNT)
        else $error("current sensor beyond store depth");

    a_poll_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.cmd == rre_pkg::CMD_POLL |=> !pending_reg)
        else $error("echo still pending after poll");

    a_missed_only_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
        result.missed_echo |-> result.trigger_fire && pending_reg)
        else $error("missed echo without pending poll");

    a_dist_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        result.distance_mm != '0 |-> item.cmd == rre_pkg::CMD_READ)
        else $error("distance on non-read word");

endmodule

`default_nettype wire

// ----- sv/round_robin_echo_ranger_top.sv -----
// round_robin_echo_ranger_top: handshake pipeline and register port around the ranger core
`timescale 1ns / 1ps
`default_nettype none

// Round robin echo ranger. Each input word (echo edge, poll tick or distance
// read) gives exactly one result word. A word passes an input register and a
// result register, and one word can be accepted every cycle while the output
// is not stalled: the scan state and distance store update in the single cycle
// a word moves from the input register to the result register. in_ready is high
// while the input register is empty or its word can move on to the result
// register, which is free when it is empty or being taken. Distances are
// floor(((end - start) mod 65536) * 17 / 100) mm, stored per sensor and
// cleared at reset. sensor_count sits at byte address 0 of the register port;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.

module round_robin_echo_ranger_top #(
    parameter int MAX_SENSORS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  edge_mask,
    input  wire logic [31:0] edge_time,
    input  wire logic [7:0]  read_index,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             trigger_fire,
    output logic [2:0]       trigger_sensor,
    output logic             missed_echo,
    output logic [15:0]      distance_mm
);

    logic [rre_pkg::COUNT_W-1:0] sensor_count_reg;
    logic                        cfg_wr;

    logic             s1_valid_reg, s1_valid_next;
    rre_pkg::item_t   s1_item_reg;
    logic             out_valid_reg, out_valid_next;
    rre_pkg::result_t out_res_reg;
    rre_pkg::result_t core_res;

    logic in_fire;
    logic out_free;
    logic s1_adv;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rre_pkg::REG_SENSOR_COUNT);
    assign prdata = (paddr[2] == rre_pkg::REG_SENSOR_COUNT)
                    ? {28'd0, sensor_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= rre_pkg::SENSOR_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            sensor_count_reg <= pwdata[rre_pkg::COUNT_W-1:0];
        end
    end

    // two stage word pipeline
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.cmd        <= cmd;
            s1_item_reg.edge_mask  <= edge_mask;
            s1_item_reg.edge_time  <= edge_time[rre_pkg::STAMP_W-1:0];
            s1_item_reg.read_index <= read_index;
        end
        if (s1_adv)
        begin
            out_res_reg <= core_res;
        end
    end

    rre_core #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s1_adv),
        .item         (s1_item_reg),
        .sensor_count (sensor_count_reg),
        .result       (core_res)
    );

    assign out_valid      = out_valid_reg;
    assign trigger_fire   = out_res_reg.trigger_fire;
    assign trigger_sensor = out_res_reg.trigger_sensor;
    assign missed_echo    = out_res_reg.missed_echo;
    assign distance_mm    = out_res_reg.distance_mm;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register overwritten while stalled");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("result register changed while stalled");

    a_fill_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && $past(out_valid_reg) == 1'b0 && out_valid_reg == 1'b0
        |=> out_valid_reg == $past(s1_valid_reg))
        else $error("result register filled without a word in the input register");

endmodule

`default_nettype wire

// ----- bench/round_robin_echo_ranger_top_tb.sv -----
// round_robin_echo_ranger_top_tb: self-checking bench for the round robin echo ranger
`timescale 1ns / 1ps

module round_robin_echo_ranger_top_tb;

    localparam logic [rre_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [2:0] ADDR_SENSOR_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
    localparam int NUM_SENSORS = 8;
    localparam int IDLE_PCT = 27;

    typedef struct {
        logic [rre_pkg::CMD_W-1:0]  cmd;
        logic [rre_pkg::MASK_W-1:0] edge_mask;
        logic [31:0]                edge_time;
        logic [rre_pkg::RIDX_W-1:0] read_index;
    } ping_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = '0;
    logic [7:0]  edge_mask = '0;
    logic [31:0] edge_time = '0;
    logic [7:0]  read_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        trigger_fire;
    logic [2:0]  trigger_sensor;
    logic        missed_echo;
    logic [15:0] distance_mm;

    // scan state as the block should hold it
    logic [rre_pkg::COUNT_W-1:0]  count_reg = rre_pkg::SENSOR_COUNT_RESET;
    logic [rre_pkg::SENSOR_W-1:0] scan_pos = '0;
    logic                         echo_armed = 1'b0;
    logic [rre_pkg::STAMP_W-1:0]  t_start = '0;
    logic [rre_pkg::STAMP_W-1:0]  t_end = '0;
    logic [rre_pkg::DIST_W-1:0]   dist_mem [NUM_SENSORS];

    ping_t            ping_q[$];
    rre_pkg::result_t expect_q[$];
    ping_t            drv_word;
    rre_pkg::result_t want;
    int               issued = 0;
    int               taken = 0;
    int               err_cnt = 0;
    int               idle_pct = IDLE_PCT;
    logic             took_word = 1'b0;
    logic [rre_pkg::SENSOR_W-1:0] plan_pos = '0;

    round_robin_echo_ranger_top #(.MAX_SENSORS(NUM_SENSORS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .edge_mask(edge_mask),
        .edge_time(edge_time), .read_index(read_index),
        .out_valid(out_valid), .out_ready(out_ready), .trigger_fire(trigger_fire),
        .trigger_sensor(trigger_sensor), .missed_echo(missed_echo),
        .distance_mm(distance_mm)
    );

    always #6 clk = ~clk;

    task automatic flag_err(input string msg);
        err_cnt++;
        $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    function automatic int eff_count();
        return (count_reg < NUM_SENSORS) ? int'(count_reg) : NUM_SENSORS;
    endfunction

    function automatic logic [rre_pkg::SENSOR_W-1:0] scan_next(
        input logic [rre_pkg::SENSOR_W-1:0] p);
        int nxt;
        nxt = int'(p) + 1;
        if (nxt >= eff_count() || nxt > 7)
            nxt = 0;
        return nxt[rre_pkg::SENSOR_W-1:0];
    endfunction

    function automatic rre_pkg::result_t range_step(input ping_t w);
        rre_pkg::result_t r;
        logic [rre_pkg::STAMP_W-1:0] span;
        r = '0;
        case (w.cmd)
            rre_pkg::CMD_EDGE:
            begin
                if (w.edge_mask[scan_pos])
                begin
                    if (!echo_armed)
                    begin
                        t_start = w.edge_time[rre_pkg::STAMP_W-1:0];
                        echo_armed = 1'b1;
                    end
                    else
                    begin
                        t_end = w.edge_time[rre_pkg::STAMP_W-1:0];
                        echo_armed = 1'b0;
                    end
                end
            end
            rre_pkg::CMD_POLL:
            begin
                if (!echo_armed)
                begin
                    span = t_end - t_start;
                    dist_mem[scan_pos] = rre_pkg::DIST_W'((32'(span) * 17) / 100);
                end
                else
                begin
                    // echo never came back: drop it, keep the old distance
                    t_start = '0;
                    t_end = '0;
                    echo_armed = 1'b0;
                    r.missed_echo = 1'b1;
                end
                scan_pos = scan_next(scan_pos);
                r.trigger_fire = 1'b1;
                r.trigger_sensor = scan_pos;
            end
            rre_pkg::CMD_READ:
            begin
                r.distance_mm = (int'(w.read_index) < eff_count()) ?
                    dist_mem[w.read_index[2:0]] : rre_pkg::DIST_BAD_INDEX;
            end
            default: ;
        endcase
        return r;
    endfunction

    // input side: one word per handshake
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || took_word)
        begin
            if (ping_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                drv_word = ping_q.pop_front();
                in_valid <= 1'b1;
                cmd <= drv_word.cmd;
                edge_mask <= drv_word.edge_mask;
                edge_time <= drv_word.edge_time;
                read_index <= drv_word.read_index;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        took_word <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            expect_q.push_back(range_step('{cmd, edge_mask, edge_time, read_index}));
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expect_q.size() == 0)
            begin
                flag_err("result word with nothing expected");
            end
            else
            begin
                want = expect_q.pop_front();
                if (trigger_fire !== want.trigger_fire)
                    flag_err($sformatf("trigger_fire %b, want %b",
                        trigger_fire, want.trigger_fire));
                if (trigger_sensor !== want.trigger_sensor)
                    flag_err($sformatf("trigger_sensor %0d, want %0d",
                        trigger_sensor, want.trigger_sensor));
                if (missed_echo !== want.missed_echo)
                    flag_err($sformatf("missed_echo %b, want %b",
                        missed_echo, want.missed_echo));
                if (distance_mm !== want.distance_mm)
                    flag_err($sformatf("distance_mm %0d, want %0d",
                        distance_mm, want.distance_mm));
            end
        end
    end

    task automatic push_word(input logic [1:0] c, input logic [7:0] m,
                             input logic [31:0] t, input logic [7:0] ri);
        ping_q.push_back('{c, m, t, ri});
        issued++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (ping_q.size() != 0 || taken != issued || expect_q.size() != 0);
        repeat (4) @(negedge clk);
        plan_pos = scan_pos;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SENSOR_COUNT)
            count_reg = data[rre_pkg::COUNT_W-1:0];
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want_rd);
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want_rd)
            flag_err($sformatf("sensor_count read %0h, want %0h", got, want_rd));
    endtask

    task automatic set_count(input logic [31:0] v);
        drain();
        apb_write(ADDR_SENSOR_COUNT, v);
        apb_check(ADDR_SENSOR_COUNT, {28'd0, v[3:0]});
        plan_pos = scan_pos;
    endtask

    task automatic plan_poll();
        push_word(rre_pkg::CMD_POLL, 8'($urandom), $urandom, 8'($urandom));
        plan_pos = scan_next(plan_pos);
    endtask

    // mostly full echo cycles on the sensor being scanned, the rest noise
    task automatic plan_scan(input int n);
        int n0;
        int pick;
        logic [7:0]  hit;
        logic [31:0] t0;
        logic [31:0] t1;
        n0 = issued;
        while (issued - n0 < n)
        begin
            pick = $urandom_range(99);
            hit = 8'(1) << plan_pos;
            t0 = $urandom;
            if (pick < 55)
            begin
                case ($urandom_range(3))
                    0: t1 = t0 + $urandom_range(0, 40);
                    1: t1 = t0 + $urandom_range(100, 30000);
                    2: t1 = t0 - $urandom_range(1, 20);
                    default: t1 = $urandom;
                endcase
                push_word(rre_pkg::CMD_EDGE, 8'($urandom) | hit, t0, 8'($urandom));
                if ($urandom_range(3) == 0)
                    push_word(rre_pkg::CMD_EDGE, 8'($urandom) & ~hit, $urandom,
                        8'($urandom));
                push_word(rre_pkg::CMD_EDGE, 8'($urandom) | hit, t1, 8'($urandom));
                plan_poll();
                if ($urandom_range(1) == 0)
                    push_word(rre_pkg::CMD_READ, 8'($urandom), $urandom,
                        8'($urandom_range(0, 8)));
            end
            else if (pick < 65)
            begin
                // echo started but never closed before the poll
                push_word(rre_pkg::CMD_EDGE, hit, t0, 8'($urandom));
                plan_poll();
            end
            else if (pick < 80)
            begin
                push_word(rre_pkg::CMD_READ, 8'($urandom), $urandom,
                    ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9)));
            end
            else if (pick < 88)
            begin
                push_word(rre_pkg::CMD_EDGE, 8'($urandom), t0, 8'($urandom));
            end
            else if (pick < 93)
            begin
                push_word(CMD_NONE, 8'($urandom), t0, 8'($urandom));
            end
            else
            begin
                plan_poll();
            end
        end
    endtask

    initial
    begin
        logic [31:0] count_plan [10];
        count_plan = '{32'd8, 32'd15, 32'd2, 32'd0, 32'd5, 32'd1, 32'd8, 32'd3, 32'd7, 32'd4};
        foreach (dist_mem[i])
            dist_mem[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one sensor after reset: cleared store, bad indexes, echo cases
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd0);
        push_word(rre_pkg::CMD_READ, 8'hFF, 32'hFFFF_FFFF, 8'd1);
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd255);
        push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        push_word(rre_pkg::CMD_EDGE, 8'h01, 32'hFFFF_0000, 8'd0);
        push_word(rre_pkg::CMD_EDGE, 8'hFE, 32'h1234_5678, 8'd0);
        push_word(rre_pkg::CMD_EDGE, 8'h81, 32'h0000_FFFF, 8'hFF);
        push_word(rre_pkg::CMD_POLL, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd0);
        // stamps that wrap past 16 bits
        push_word(rre_pkg::CMD_EDGE, 8'h01, 32'h0000_FFF0, 8'd0);
        push_word(rre_pkg::CMD_EDGE, 8'h01, 32'hFFFF_0010, 8'd0);
        push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd0);
        push_word(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        push_word(rre_pkg::CMD_EDGE, 8'h01, 32'h0000_0100, 8'd0);
        push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd0);

        // walk up to sensor 5, then shrink the count under it
        set_count(32'd8);
        repeat (5) push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        set_count(32'd3);
        push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        set_count(32'd0);
        push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd0);
        set_count(32'd15);
        apb_write(ADDR_UNMAPPED, 32'h0000_0002);
        push_word(rre_pkg::CMD_POLL, 8'h00, 32'h0, 8'd0);
        push_word(rre_pkg::CMD_READ, 8'h00, 32'h0, 8'd7);

        foreach (count_plan[k])
        begin
            set_count(count_plan[k]);
            idle_pct = (k == 3) ? 0 : IDLE_PCT;
            if (k == 5)
            begin
                plan_scan(18);
                drain();
                plan_scan(22);
            end
            else
            begin
                plan_scan(40);
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (err_cnt == 0)
            $display("round_robin_echo_ranger_top_tb: PASS");
        else
            $display("round_robin_echo_ranger_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("round_robin_echo_ranger_top_tb: FAIL");
        $finish;
    end

endmodule
